### design/vcd_pkg.sv
// ----------------------------------------------------------------------------
// vcd_pkg
// Shared constants, codes and control/status types of the emulated disk.
// ----------------------------------------------------------------------------
package vcd_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int NUM_SECTORS  = 64;
    localparam int BYTE_W       = $clog2(SECTOR_BYTES);
    localparam int SEC_W        = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
    localparam int ADDR_W       = BYTE_W + SEC_W;
    localparam int LEN_W        = 16;
    localparam int NSEC_W       = LEN_W - BYTE_W;
    localparam int DCNT_W       = 7;
    localparam int DRAW_W       = 24;

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_INC = 32'd12345;

    // command codes
    localparam logic [2:0] CMD_RD_REQ  = 3'd0;
    localparam logic [2:0] CMD_RD_BEAT = 3'd1;
    localparam logic [2:0] CMD_WR_REQ  = 3'd2;
    localparam logic [2:0] CMD_WR_BEAT = 3'd3;
    localparam logic [2:0] CMD_FLUSH   = 3'd4;
    localparam logic [2:0] CMD_CRASH   = 3'd5;

    // fault kinds
    localparam logic [2:0] FK_NONE  = 3'd0;
    localparam logic [2:0] FK_EIO   = 3'd1;
    localparam logic [2:0] FK_CHG   = 3'd2;
    localparam logic [2:0] FK_INTR  = 3'd3;
    localparam logic [2:0] FK_SHORT = 3'd4;
    localparam logic [2:0] FK_TSEC  = 3'd5;
    localparam logic [2:0] FK_TBYTE = 3'd6;
    localparam logic [2:0] FK_DROP  = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK = 2'd0;

    // write modes
    localparam logic [1:0] WM_NONE  = 2'd0;
    localparam logic [1:0] WM_PLAIN = 2'd1;
    localparam logic [1:0] WM_TSEC  = 2'd2;
    localparam logic [1:0] WM_TBYTE = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_CONSUME,
        OP_DRAW,
        OP_DIV_START,
        OP_REQ_FIN,
        OP_RD_TAKE,
        OP_WR_BEAT,
        OP_SCAN_STEP,
        OP_END
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   ld_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic       short_need;
        logic       beat_ok_rd;
        logic       beat_ok_wr;
        logic       wr_draw;
        logic       cnt_last;
        logic       scan_last;
        logic       div_done;
        logic       flush_skip;
    } t_dp_stat;

endpackage

### design/vcd_div.sv
// ----------------------------------------------------------------------------
// vcd_div
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module vcd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vcd_pkg::DRAW_W-1:0]  i_dividend,
    input  logic [vcd_pkg::LEN_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [vcd_pkg::LEN_W-1:0]   o_rem
);
    import vcd_pkg::*;

    localparam int CNT_W = $clog2(DRAW_W);

    logic [DRAW_W-1:0] r_num;
    logic [LEN_W-1:0]  r_div;
    logic [LEN_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [LEN_W:0]    w_trial;
    logic [LEN_W-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_num[DRAW_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = LEN_W'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = w_trial[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[DRAW_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DRAW_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### design/vcd_ctrl.sv
// ----------------------------------------------------------------------------
// vcd_ctrl
// Sequencer: clear pass, item decode, request/beat/copy steps, result hand-off.
// ----------------------------------------------------------------------------
module vcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  vcd_pkg::t_dp_stat i_stat,
    output vcd_pkg::t_dp_cmd  o_cmd
);
    import vcd_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_REQ_CHK, S_DIV_GO, S_DIV,
        S_BEAT_RD, S_WR_BEAT, S_COPY, S_END, S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = OP_NONE;
        o_cmd.ld_out  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.cnt_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESULT;
                case (i_stat.cmd)
                    CMD_RD_REQ, CMD_WR_REQ: begin
                        o_cmd.op = OP_CONSUME;
                        n_state  = S_REQ_CHK;
                    end
                    CMD_RD_BEAT: begin
                        if (i_stat.beat_ok_rd) n_state = S_BEAT_RD;
                    end
                    CMD_WR_BEAT: begin
                        if (i_stat.beat_ok_wr) begin
                            if (i_stat.wr_draw) begin
                                o_cmd.op = OP_DRAW;
                                n_state  = S_WR_BEAT;
                            end else begin
                                o_cmd.op = OP_WR_BEAT;
                            end
                        end
                    end
                    CMD_FLUSH: begin
                        if (i_stat.flush_skip) o_cmd.op = OP_END;
                        else n_state = S_COPY;
                    end
                    CMD_CRASH: n_state = S_COPY;
                    default: n_state = S_RESULT;
                endcase
            end
            S_REQ_CHK: begin
                if (i_stat.short_need) begin
                    o_cmd.op = OP_DRAW;
                    n_state  = S_DIV_GO;
                end else begin
                    o_cmd.op = OP_REQ_FIN;
                    n_state  = S_RESULT;
                end
            end
            S_DIV_GO: begin
                o_cmd.op = OP_DIV_START;
                n_state  = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_REQ_FIN;
                    n_state  = S_RESULT;
                end
            end
            S_BEAT_RD: begin
                o_cmd.op = OP_RD_TAKE;
                n_state  = S_RESULT;
            end
            S_WR_BEAT: begin
                o_cmd.op = OP_WR_BEAT;
                n_state  = S_RESULT;
            end
            S_COPY: begin
                o_cmd.op = OP_SCAN_STEP;
                if (i_stat.scan_last) n_state = S_END;
            end
            S_END: begin
                // last copy write lands in this cycle
                o_cmd.op = OP_END;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                if (w_out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.ld_out) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### design/vcd_dp.sv
// ----------------------------------------------------------------------------
// vcd_dp
// Datapath: live and stable images, dirty map, fault and transfer state, LCG.
// ----------------------------------------------------------------------------
module vcd_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [31:0]                 i_cfg_wr_data,
    input  logic [2:0]                  i_cmd,
    input  logic [14:0]                 i_byte_offset,
    input  logic [15:0]                 i_request_length,
    input  logic [7:0]                  i_write_byte,
    input  logic                        i_arm_fault,
    input  logic [2:0]                  i_fault_kind,
    input  logic [15:0]                 i_fault_count,
    input  vcd_pkg::t_dp_cmd            i_dcmd,
    output vcd_pkg::t_dp_stat           o_stat,
    output logic [1:0]                  o_status,
    output logic [15:0]                 o_accepted_length,
    output logic [7:0]                  o_read_byte,
    output logic [6:0]                  o_dirty_count
);
    import vcd_pkg::*;

    localparam int DISK_BYTES = SECTOR_BYTES * NUM_SECTORS;

    logic [7:0] mem_live   [DISK_BYTES];
    logic [7:0] mem_stable [DISK_BYTES];
    logic [7:0] r_live_q, r_stable_q;

    // latched item
    logic [2:0]        r_cmd;
    logic [ADDR_W-1:0] r_off;
    logic [LEN_W-1:0]  r_len;
    logic [7:0]        r_wbyte;
    logic              r_arm;
    logic [2:0]        r_kind;
    logic [15:0]       r_count;

    // state
    logic [NUM_SECTORS-1:0] r_dirty;
    logic [DCNT_W-1:0]      r_total;
    logic [31:0]            r_lcg;
    logic [2:0]             r_armed;
    logic [15:0]            r_frem;
    logic [ADDR_W-1:0]      r_ptr;
    logic [LEN_W-1:0]       r_trem;
    logic [1:0]             r_wmode;
    logic                   r_lands;
    logic [2:0]             r_f;
    logic                   r_short;
    logic [ADDR_W-1:0]      r_cnt;
    logic                   r_cp_wen;
    logic [ADDR_W-1:0]      r_cp_wa;
    logic                   r_to_stable;

    // result
    logic [1:0]       r_res_status;
    logic [LEN_W-1:0] r_res_acc;
    logic [7:0]       r_res_rbyte;
    logic [1:0]       r_o_status;
    logic [LEN_W-1:0] r_o_acc;
    logic [7:0]       r_o_rbyte;
    logic [6:0]       r_o_dirty;

    logic [31:0]       w_lcg_next;
    logic [SEC_W-1:0]  w_ptr_sec, w_cnt_sec;
    logic              w_at_start, w_lands, w_store;
    logic [NSEC_W-1:0] w_nsec;
    logic [LEN_W-1:0]  w_divisor, w_rem, w_len_fin;
    logic              w_div_done;
    logic              w_is_rd;
    logic [2:0]        w_consume;

    logic              w_live_we, w_stable_we;
    logic [ADDR_W-1:0] w_live_wa, w_stable_wa, w_live_ra;
    logic [7:0]        w_live_wd, w_stable_wd;

    assign w_lcg_next = r_lcg * LCG_MUL + LCG_INC;
    assign w_ptr_sec  = r_ptr[ADDR_W-1:BYTE_W];
    assign w_cnt_sec  = r_cnt[ADDR_W-1:BYTE_W];
    assign w_at_start = (r_ptr[BYTE_W-1:0] == '0);
    assign w_nsec     = r_len[LEN_W-1:BYTE_W];
    assign w_is_rd    = (r_cmd == CMD_RD_REQ);

    // the draw's low bit is bit 8 of the LCG value
    assign w_lands = w_at_start ? !((r_wmode == WM_TSEC) && r_lcg[8]) : r_lands;
    assign w_store = w_lands && ((r_wmode != WM_TBYTE) || r_lcg[8]);

    assign w_divisor = w_is_rd ? r_len : LEN_W'(w_nsec);

    always_comb begin
        if (!r_short) begin
            w_len_fin = r_len;
        end else if (w_is_rd) begin
            w_len_fin = LEN_W'(w_rem + 1'b1);
        end else begin
            w_len_fin = {NSEC_W'(w_rem[NSEC_W-1:0] + 1'b1), {BYTE_W{1'b0}}};
        end
    end

    always_comb begin
        w_consume = r_armed;
        if (w_is_rd && (r_armed >= FK_TSEC)) w_consume = FK_NONE;
    end

    vcd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_dcmd.op == OP_DIV_START),
        .i_dividend (r_lcg[31:8]),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // memory ports
    always_comb begin
        w_live_we   = 1'b0;
        w_live_wa   = r_cp_wa;
        w_live_wd   = r_stable_q;
        w_stable_we = 1'b0;
        w_stable_wa = r_cp_wa;
        w_stable_wd = r_live_q;
        w_live_ra   = (i_dcmd.op == OP_SCAN_STEP) ? r_cnt : r_ptr;
        if (i_dcmd.op == OP_CLEAR) begin
            w_live_we   = 1'b1;
            w_live_wa   = r_cnt;
            w_live_wd   = '0;
            w_stable_we = 1'b1;
            w_stable_wa = r_cnt;
            w_stable_wd = '0;
        end else if (i_dcmd.op == OP_WR_BEAT) begin
            w_live_we = w_store;
            w_live_wa = r_ptr;
            w_live_wd = r_wbyte;
        end else if (r_cp_wen) begin
            w_live_we   = !r_to_stable;
            w_stable_we = r_to_stable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_live_we) mem_live[w_live_wa] <= w_live_wd;
        r_live_q <= mem_live[w_live_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_stable_we) mem_stable[w_stable_wa] <= w_stable_wd;
        r_stable_q <= mem_stable[r_cnt];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_dcmd.op == OP_LATCH) begin
            r_cmd       <= i_cmd;
            r_off       <= i_byte_offset;
            r_len       <= i_request_length;
            r_wbyte     <= i_write_byte;
            r_arm       <= i_arm_fault;
            r_kind      <= i_fault_kind;
            r_count     <= i_fault_count;
            r_to_stable <= (i_cmd == CMD_FLUSH);
        end
        if (i_dcmd.ld_out) begin
            r_o_status <= r_res_status;
            r_o_acc    <= r_res_acc;
            r_o_rbyte  <= r_res_rbyte;
            r_o_dirty  <= r_total;
        end
        r_cp_wa <= r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty      <= '0;
            r_total      <= '0;
            r_lcg        <= '0;
            r_armed      <= FK_NONE;
            r_frem       <= '0;
            r_ptr        <= '0;
            r_trem       <= '0;
            r_wmode      <= WM_NONE;
            r_lands      <= 1'b0;
            r_f          <= FK_NONE;
            r_short      <= 1'b0;
            r_cnt        <= '0;
            r_cp_wen     <= 1'b0;
            r_res_status <= ST_OK;
            r_res_acc    <= '0;
            r_res_rbyte  <= '0;
        end else begin
            r_cp_wen <= 1'b0;
            if (i_cfg_wr_en) r_lcg <= i_cfg_wr_data;
            case (i_dcmd.op)
                OP_CLEAR: r_cnt <= r_cnt + 1'b1;
                OP_LATCH: begin
                    r_cnt        <= '0;
                    r_short      <= 1'b0;
                    r_res_status <= ST_OK;
                    r_res_acc    <= '0;
                    r_res_rbyte  <= '0;
                end
                OP_CONSUME: begin
                    r_f     <= w_consume;
                    r_trem  <= '0;
                    r_wmode <= WM_NONE;
                    if (w_consume != FK_NONE && r_frem != '0) begin
                        r_frem <= r_frem - 1'b1;
                        if (r_frem == 16'd1) r_armed <= FK_NONE;
                    end
                end
                OP_DRAW: r_lcg <= w_lcg_next;
                OP_DIV_START: r_short <= 1'b1;
                OP_REQ_FIN: begin
                    if (r_f == FK_EIO || r_f == FK_CHG || r_f == FK_INTR) begin
                        r_res_status <= r_f[1:0];
                    end else begin
                        r_res_acc <= w_len_fin;
                        if (w_is_rd) begin
                            r_ptr  <= r_off;
                            r_trem <= w_len_fin;
                        end else if (r_f != FK_DROP) begin
                            r_ptr  <= {r_off[ADDR_W-1:BYTE_W], {BYTE_W{1'b0}}};
                            r_trem <= {w_len_fin[LEN_W-1:BYTE_W], {BYTE_W{1'b0}}};
                            if (w_len_fin[LEN_W-1:BYTE_W] == '0) r_wmode <= WM_NONE;
                            else if (r_f == FK_TSEC) r_wmode <= WM_TSEC;
                            else if (r_f == FK_TBYTE) r_wmode <= WM_TBYTE;
                            else r_wmode <= WM_PLAIN;
                        end
                    end
                end
                OP_RD_TAKE: begin
                    r_res_rbyte <= r_live_q;
                    r_ptr       <= r_ptr + 1'b1;
                    r_trem      <= r_trem - 1'b1;
                end
                OP_WR_BEAT: begin
                    r_lands <= w_lands;
                    if (w_at_start && w_lands && !r_dirty[w_ptr_sec]) begin
                        r_dirty[w_ptr_sec] <= 1'b1;
                        r_total            <= r_total + 1'b1;
                    end
                    r_ptr  <= r_ptr + 1'b1;
                    r_trem <= r_trem - 1'b1;
                    if (r_trem == LEN_W'(1)) r_wmode <= WM_NONE;
                end
                OP_SCAN_STEP: begin
                    if (r_dirty[w_cnt_sec]) begin
                        r_cp_wen <= 1'b1;
                        r_cnt    <= r_cnt + 1'b1;
                        if (r_cnt[BYTE_W-1:0] == '1) r_dirty[w_cnt_sec] <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + ADDR_W'(SECTOR_BYTES);
                    end
                end
                OP_END: begin
                    r_total <= '0;
                    if (r_cmd == CMD_FLUSH) begin
                        if (r_arm) begin
                            r_armed <= r_kind;
                            r_frem  <= r_count;
                        end
                    end else begin
                        r_armed <= FK_NONE;
                        r_frem  <= '0;
                        r_trem  <= '0;
                        r_wmode <= WM_NONE;
                        r_lands <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.short_need = (r_f == FK_SHORT) &&
                            (w_is_rd ? (r_len > LEN_W'(1)) : (w_nsec > NSEC_W'(1)));
        o_stat.beat_ok_rd = (r_wmode == WM_NONE) && (r_trem != '0);
        o_stat.beat_ok_wr = (r_wmode != WM_NONE) && (r_trem != '0);
        o_stat.wr_draw    = (r_wmode == WM_TBYTE) || ((r_wmode == WM_TSEC) && w_at_start);
        o_stat.cnt_last   = (r_cnt == '1);
        o_stat.scan_last  = (w_cnt_sec == SEC_W'(NUM_SECTORS - 1)) &&
                            (!r_dirty[w_cnt_sec] || (r_cnt[BYTE_W-1:0] == '1));
        o_stat.div_done   = w_div_done;
        o_stat.flush_skip = (r_total == '0);
    end

    assign o_status          = r_o_status;
    assign o_accepted_length = r_o_acc;
    assign o_read_byte       = r_o_rbyte;
    assign o_dirty_count     = r_o_dirty;

endmodule

### design/volatile_cache_disk_fault_model_top.sv
// ----------------------------------------------------------------------------
// volatile_cache_disk_fault_model_top
// Emulated disk with a volatile write cache and seeded fault injection.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over both disk images, one byte
// a cycle, and stalls its input until it is done. Then every item takes a
// decode step plus its work, all through byte memories with one read and
// one write port. A request shortened by a fault adds an LCG draw and a run
// of the 24-step remainder unit. A flush with nothing dirty ends straight
// after decode; otherwise flush and crash walk the 64 sectors one a cycle
// and copy each dirty sector byte by byte. One item is in work at a time;
// the output register lets the next item in while a result is still waiting
// to be taken.
module volatile_cache_disk_fault_model_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [14:0] i_byte_offset,
    input  logic [15:0] i_request_length,
    input  logic [7:0]  i_write_byte,
    input  logic        i_arm_fault,
    input  logic [2:0]  i_fault_kind,
    input  logic [15:0] i_fault_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_accepted_length,
    output logic [7:0]  o_read_byte,
    output logic [6:0]  o_dirty_count
);
    import vcd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    vcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    vcd_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_cmd             (i_cmd),
        .i_byte_offset     (i_byte_offset),
        .i_request_length  (i_request_length),
        .i_write_byte      (i_write_byte),
        .i_arm_fault       (i_arm_fault),
        .i_fault_kind      (i_fault_kind),
        .i_fault_count     (i_fault_count),
        .i_dcmd            (w_cmd),
        .o_stat            (w_stat),
        .o_status          (o_status),
        .o_accepted_length (o_accepted_length),
        .o_read_byte       (o_read_byte),
        .o_dirty_count     (o_dirty_count)
    );

endmodule
